// ----- design/a2i_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package a2i_pkg;

	localparam int unsigned MAX_CHARS_DEF = 4096;

	localparam int unsigned BASE_W = 6;
	localparam int unsigned DIG_W  = 7;

	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
	localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

	localparam logic [DIG_W-1:0] DIGIT_NONE = 7'd99;

	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_BAD_BASE = 2'd2;

	typedef enum logic [2:0] {
		PH_SKIPWS = 3'd0,
		PH_START  = 3'd1,
		PH_ZERO   = 3'd2,
		PH_XSEEN  = 3'd3,
		PH_DIGITS = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [BASE_W-1:0] base;
		logic              neg;
		logic [63:0]       mag;
		logic              ovf;
	} parse_state_t;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
	} parse_result_t;

	function automatic logic [DIG_W-1:0] digit_value(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				t = c - 8'h30;
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				t = c - 8'h61 + 8'd10;
			end else if (c >= 8'h41 && c <= 8'h5A) begin
				t = c - 8'h41 + 8'd10;
			end else begin
				t = {1'b0, DIGIT_NONE};
			end
			return t[DIG_W-1:0];
		end
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic base_bad(input logic [BASE_W-1:0] b);
		return (b == BASE_ONE) || (b > BASE_MAX);
	endfunction

endpackage
`default_nettype wire

// ----- design/a2i_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
module a2i_step
	import a2i_pkg::*;
#(
	parameter int unsigned MAX_CHARS = MAX_CHARS_DEF,
	parameter int unsigned CNT_W     = $clog2(MAX_CHARS + 1)
) (
	input  parse_state_t      cur,
	input  logic [CNT_W-1:0]  char_count,
	input  logic [CNT_W-1:0]  end_offset,
	input  logic [BASE_W-1:0] number_base,
	input  logic [7:0]        character,
	output parse_state_t      nxt,
	output logic [CNT_W-1:0]  nxt_count,
	output logic [CNT_W-1:0]  nxt_end,
	output parse_result_t     res,
	output logic [CNT_W-1:0]  consumed
);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);
	localparam logic [69:0] LIM_POS = {6'd0, POS_LIMIT};
	localparam logic [69:0] LIM_NEG = {6'd0, NEG_LIMIT};

	logic              first;
	logic [BASE_W-1:0] wb;
	logic              bad;
	phase_t            ph;
	logic [BASE_W-1:0] tb;
	logic              take;
	logic [DIG_W-1:0]  d;
	logic              dig_ok;
	logic [69:0]       prod;
	logic [69:0]       sum;
	logic              over;
	logic [CNT_W-1:0]  bumped;

	assign first  = (char_count == '0) && (cur.phase == PH_SKIPWS);
	assign wb     = first ? number_base : cur.base;
	assign bad    = base_bad(wb);
	assign ph     = (first && bad) ? PH_DONE : cur.phase;
	assign bumped = (char_count < CNT_MAX) ? char_count + 1'b1 : CNT_MAX;

	assign d      = digit_value(character);
	assign dig_ok = (tb >= 6'd2) && (d < {1'b0, tb});
	assign prod   = 70'(cur.mag) * 70'(tb);
	assign sum    = prod + 70'(d);
	assign over   = sum > (cur.neg ? LIM_NEG : LIM_POS);

	always_comb begin
		tb   = wb;
		take = 1'b0;
		unique case (ph)
			PH_SKIPWS, PH_START: begin
				if (ph == PH_SKIPWS && (is_space(character) || character == 8'h2D
						|| character == 8'h2B)) begin
					take = 1'b0;
				end else if ((wb == BASE_AUTO || wb == BASE_HEX) && character == 8'h30) begin
					take = 1'b0;
				end else begin
					tb   = (wb == BASE_AUTO) ? BASE_DEC : wb;
					take = 1'b1;
				end
			end
			PH_ZERO: begin
				if (character != 8'h78 && character != 8'h58) begin
					tb   = (wb == BASE_AUTO) ? BASE_OCT : wb;
					take = 1'b1;
				end
			end
			PH_XSEEN, PH_DIGITS: begin
				take = 1'b1;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	always_comb begin
		nxt      = cur;
		nxt.base = wb;
		nxt.phase = ph;
		nxt_end  = end_offset;
		unique case (ph)
			PH_SKIPWS, PH_START: begin
				if (ph == PH_SKIPWS && is_space(character)) begin
					nxt.phase = PH_SKIPWS;
				end else if (ph == PH_SKIPWS && character == 8'h2D) begin
					nxt.neg   = 1'b1;
					nxt.phase = PH_START;
				end else if (ph == PH_SKIPWS && character == 8'h2B) begin
					nxt.phase = PH_START;
				end else if ((wb == BASE_AUTO || wb == BASE_HEX) && character == 8'h30) begin
					nxt_end   = bumped;
					nxt.phase = PH_ZERO;
				end
			end
			PH_ZERO: begin
				if (character == 8'h78 || character == 8'h58) begin
					nxt.base  = BASE_HEX;
					nxt.phase = PH_XSEEN;
				end
			end
			PH_XSEEN, PH_DIGITS: begin
				nxt.phase = ph;
			end
			default: begin
				nxt.phase = ph;
			end
		endcase
		if (take) begin
			nxt.base = tb;
			if (!dig_ok) begin
				nxt.phase = PH_DONE;
			end else begin
				if (!cur.ovf) begin
					if (over) begin
						nxt.ovf = 1'b1;
					end else begin
						nxt.mag = sum[63:0];
					end
				end
				nxt_end   = bumped;
				nxt.phase = PH_DIGITS;
			end
		end
	end

	assign nxt_count = bumped;

	always_comb begin
		if (bad) begin
			res.value  = POS_LIMIT;
			res.status = ST_BAD_BASE;
			consumed   = '0;
		end else if (nxt.ovf) begin
			res.value  = nxt.neg ? NEG_LIMIT : POS_LIMIT;
			res.status = ST_OVERFLOW;
			consumed   = nxt_end;
		end else begin
			res.value  = nxt.neg ? (64'd0 - nxt.mag) : nxt.mag;
			res.status = ST_OK;
			consumed   = nxt_end;
		end
	end

endmodule
`default_nettype wire

// ----- design/a2i_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module a2i_out_reg
	import a2i_pkg::*;
#(
	parameter int unsigned CNT_W = $clog2(MAX_CHARS_DEF + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [63:0]      load_value,
	input  logic [CNT_W-1:0] load_consumed,
	input  logic [1:0]       load_status,
	output logic             room,
	input  logic             result_stall,
	output logic             result_valid,
	output logic [63:0]      value,
	output logic [CNT_W-1:0] consumed,
	output logic [1:0]       status
);

	logic             valid_q;
	logic [63:0]      value_q;
	logic [CNT_W-1:0] consumed_q;
	logic [1:0]       status_q;

	assign room = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (room && load) begin
			value_q    <= load_value;
			consumed_q <= load_consumed;
			status_q   <= load_status;
		end
	end

	assign result_valid = valid_q;
	assign value        = value_q;
	assign consumed     = consumed_q;
	assign status       = status_q;

endmodule
`default_nettype wire

// ----- design/ascii_to_int64_parser_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                   Payload
// input     char_valid / char_stall     character, last_char
// result    result_valid / result_stall value, consumed, status
// config    number_base_we              number_base
//
// One character per cycle while char_stall is low: each request lands in an
// input register and the parse state steps once per character through one 64x6
// multiply-add and compare; the last character loads the result register.
// Reset clears the parse state and the base register to automatic detection.
// A held result stalls only the last character of the next string.
module ascii_to_int64_parser_top
	import a2i_pkg::*;
#(
	parameter int unsigned MAX_CHARS = MAX_CHARS_DEF,
	parameter int unsigned CNT_W     = $clog2(MAX_CHARS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              number_base_we,
	input  wire logic [BASE_W-1:0] number_base,
	input  wire logic              char_valid,
	output logic                   char_stall,
	input  wire logic [7:0]        character,
	input  wire logic              last_char,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic signed [63:0]     value,
	output logic [CNT_W-1:0]       consumed,
	output logic [1:0]             status
);

	localparam parse_state_t CLEAR_STATE = '{
		phase: PH_SKIPWS, base: BASE_AUTO, neg: 1'b0, mag: 64'd0, ovf: 1'b0
	};

	logic [BASE_W-1:0] number_base_q;
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              last_s1;
	logic              fire_s1;
	logic              room;
	parse_state_t      state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  end_q;
	parse_state_t      nxt;
	logic [CNT_W-1:0]  nxt_count;
	logic [CNT_W-1:0]  nxt_end;
	parse_result_t     res;
	logic [CNT_W-1:0]  res_consumed;
	logic [63:0]       value_u;

	assign fire_s1    = valid_s1 && (!last_s1 || room);
	assign char_stall = valid_s1 && !fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_AUTO;
		end else if (number_base_we) begin
			number_base_q <= number_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= character;
			last_s1 <= last_char;
		end
	end

	a2i_step #(
		.MAX_CHARS(MAX_CHARS),
		.CNT_W    (CNT_W)
	) u_step (
		.cur        (state_q),
		.char_count (count_q),
		.end_offset (end_q),
		.number_base(number_base_q),
		.character  (char_s1),
		.nxt        (nxt),
		.nxt_count  (nxt_count),
		.nxt_end    (nxt_end),
		.res        (res),
		.consumed   (res_consumed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR_STATE;
			count_q <= '0;
			end_q   <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				state_q <= CLEAR_STATE;
				count_q <= '0;
				end_q   <= '0;
			end else begin
				state_q <= nxt;
				count_q <= nxt_count;
				end_q   <= nxt_end;
			end
		end
	end

	a2i_out_reg #(
		.CNT_W(CNT_W)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire_s1 && last_s1),
		.load_value   (res.value),
		.load_consumed(res_consumed),
		.load_status  (res.status),
		.room         (room),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.value        (value_u),
		.consumed     (consumed),
		.status       (status)
	);

	assign value = signed'(value_u);

endmodule
`default_nettype wire
